/* rtl/aes256_gcm_pkg.sv */
// ----------------------------------------------------------------------------
// AES-256-GCM package
// Payload types, operation codes and the AES helper functions.
// ----------------------------------------------------------------------------
package aes256_gcm_pkg;

   typedef enum logic [1:0] {
      OP_AAD    = 2'd0,
      OP_TEXT   = 2'd1,
      OP_FINISH = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_ERROR    = 2'd2;

   localparam logic [1:0] PHASE_AAD_OPEN    = 2'd0;
   localparam logic [1:0] PHASE_AAD_CLOSED  = 2'd1;
   localparam logic [1:0] PHASE_TEXT_OPEN   = 2'd2;
   localparam logic [1:0] PHASE_TEXT_CLOSED = 2'd3;

   localparam logic [2:0] REG_KEY0      = 3'd0;
   localparam logic [2:0] REG_KEY1      = 3'd1;
   localparam logic [2:0] REG_KEY2      = 3'd2;
   localparam logic [2:0] REG_KEY3      = 3'd3;
   localparam logic [2:0] REG_NONCE_HI  = 3'd4;
   localparam logic [2:0] REG_NONCE_LO  = 3'd5;
   localparam logic [2:0] REG_DIRECTION = 3'd6;

   localparam logic [60:0] AAD_MAX_BYTES  = 61'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [35:0] TEXT_MAX_BYTES = 36'hF_FFFF_FFE0;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic [4:0]  out_bytes;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // One AES round without the key addition; byte 0 sits in bits 127:120.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
      for (int row = 0; row < 4; row++)
         for (int c = 0; c < 4; c++)
            t[4*c+row] = b[4*((c+row)%4)+row];
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         if (!last) begin
            b[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            b[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            b[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            b[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end else begin
            b[4*c] = a0; b[4*c+1] = a1; b[4*c+2] = a2; b[4*c+3] = a3;
         end
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
      return r;
   endfunction

   // Eight steps of the bit-serial GF(2^128) multiply.
   function automatic logic [255:0] gf_steps(input logic [127:0] z, input logic [127:0] v,
                                             input logic [7:0] bits);
      logic [127:0] zz, vv;
      logic lsb;
      zz = z;
      vv = v;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) zz = zz ^ vv;
         lsb = vv[0];
         vv = {1'b0, vv[127:1]};
         if (lsb) vv[127:120] = vv[127:120] ^ 8'hE1;
      end
      return {zz, vv};
   endfunction

endpackage

/* rtl/aes256_gcm_authenticated_cipher.sv */
// ----------------------------------------------------------------------------
// AES-256-GCM authenticated cipher
// Sequential engine: round keys in a synchronous memory, one AES round at a
// time and eight GHASH bits per cycle.
// ----------------------------------------------------------------------------
// The first item after reset or a key/IV write first runs key expansion and
// the two setup encryptions. Valid AAD and finish items then go straight to the
// hash, text items first run the 15 AES rounds (each round fetches four key
// words) and then the hash, and a rejected item goes straight to its result.
// One item at a time; the next is accepted once the result has left.
// Reset is synchronous; keys must be expanded again after reset.
module aes256_gcm_authenticated_cipher (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  aes256_gcm_pkg::req_type      req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output aes256_gcm_pkg::rsp_type      rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [5:0]                   paddr,
   input  logic [63:0]                  pwdata,
   output logic [63:0]                  prdata,
   output logic                         pready
);
   import aes256_gcm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_KEXP, ST_KRD, ST_ENC_LOAD, ST_ENC, ST_SETUP_DONE,
      ST_DISPATCH, ST_HASH, ST_RESP
   } state_type;

   state_type state_ff;
   logic [63:0] key_ff [4];
   logic [63:0] nonce_high_ff;
   logic [31:0] nonce_low_ff;
   logic        direction_ff;
   logic        keys_ready_ff;

   logic [31:0] rk_mem [60];
   logic [31:0] rk_rdata_ff;
   logic [5:0]  rk_raddr;
   logic        rk_we;
   logic [5:0]  rk_waddr;
   logic [31:0] rk_wdata;

   logic [127:0] hkey_ff, tmask_ff, acc_ff;
   logic [31:0]  ctr_ff;
   logic [60:0]  aad_total_ff;
   logic [35:0]  text_total_ff;
   logic [1:0]   phase_ff;

   logic [5:0]   kidx_ff;
   logic [31:0]  w1_ff;
   logic [7:0]   rcon_ff;
   logic [255:0] window_ff;
   logic [127:0] blk_ff, ks_ff;
   logic [3:0]   round_ff;
   logic [1:0]   word_ff;
   logic [127:0] rk_acc_ff;
   logic         setup_pass_ff;
   logic [127:0] gz_ff, gv_ff, gy_ff;
   logic [3:0]   gcnt_ff;
   req_type      req_ff;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff;
   logic [127:0] mask;

   logic cfg_write;
   assign cfg_write = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      case (paddr[5:3])
         REG_KEY0:      prdata = key_ff[0];
         REG_KEY1:      prdata = key_ff[1];
         REG_KEY2:      prdata = key_ff[2];
         REG_KEY3:      prdata = key_ff[3];
         REG_NONCE_HI:  prdata = nonce_high_ff;
         REG_NONCE_LO:  prdata = {32'd0, nonce_low_ff};
         REG_DIRECTION: prdata = {63'd0, direction_ff};
         default:       prdata = 64'd0;
      endcase
   end

   // Byte mask of the valid leading bytes.
   always_comb begin
      for (int i = 0; i < 16; i++)
         mask[127-8*i -: 8] = (5'(i) < req_ff.byte_count) ? 8'hFF : 8'h00;
   end

   // Key expansion word from the sliding window of the last eight words.
   logic [31:0] kexp_word;
   always_comb begin
      logic [31:0] t;
      t = window_ff[31:0];
      if (kidx_ff[2:0] == 3'd0)
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'd0};
      else if (kidx_ff[2:0] == 3'd4)
         t = sub_word(t);
      kexp_word = window_ff[255:224] ^ t;
   end

   always_comb begin
      rk_we = 1'b0;
      rk_waddr = kidx_ff;
      rk_wdata = kexp_word;
      if (state_ff == ST_KEXP) begin
         rk_we = 1'b1;
         rk_wdata = (kidx_ff < 6'd8) ? window_ff[255:224] : kexp_word;
      end
      rk_raddr = 6'({round_ff, word_ff});
   end

   always_ff @(posedge clock) begin
      if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
      rk_rdata_ff <= rk_mem[rk_raddr];
   end

   logic accept_in, send_out;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept_in = req_valid && req_ready;
   assign send_out  = rsp_valid_ff && rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic bad_n;
   assign bad_n = (req_ff.byte_count == 5'd0) || (req_ff.byte_count > 5'd16);
   logic [127:0] round_out;
   assign round_out = aes_round(blk_ff, round_ff == 4'd14);
   logic [255:0] gstep;
   assign gstep = gf_steps(gz_ff, gv_ff, gy_ff[127:120]);
   logic [127:0] text_out, tag;
   assign text_out = ({req_ff.data_high, req_ff.data_low} ^ ks_ff) & mask;
   // The tag is taken from the last hash step, before the accumulator clears.
   assign tag = gstep[255:128] ^ tmask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) key_ff[i] <= 64'd0;
         nonce_high_ff <= 64'd0;
         nonce_low_ff <= 32'd0;
         direction_ff <= 1'b0;
         acc_ff <= '0;
         ctr_ff <= 32'd2;
         aad_total_ff <= '0;
         text_total_ff <= '0;
         phase_ff <= PHASE_AAD_OPEN;
      end else begin
         if (send_out) rsp_valid_ff <= 1'b0;
         if (cfg_write && paddr[5:3] <= REG_DIRECTION) begin
            case (paddr[5:3])
               REG_KEY0:      key_ff[0] <= pwdata;
               REG_KEY1:      key_ff[1] <= pwdata;
               REG_KEY2:      key_ff[2] <= pwdata;
               REG_KEY3:      key_ff[3] <= pwdata;
               REG_NONCE_HI:  nonce_high_ff <= pwdata;
               REG_NONCE_LO:  nonce_low_ff <= pwdata[31:0];
               default:       direction_ff <= pwdata[0];
            endcase
            if (paddr[5:3] != REG_DIRECTION) begin
               keys_ready_ff <= 1'b0;
               acc_ff <= '0;
               ctr_ff <= 32'd2;
               aad_total_ff <= '0;
               text_total_ff <= '0;
               phase_ff <= PHASE_AAD_OPEN;
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  req_ff <= req_data;
                  if (keys_ready_ff) state_ff <= ST_DISPATCH;
                  else begin
                     state_ff <= ST_KEXP;
                     kidx_ff <= 6'd0;
                     rcon_ff <= 8'h01;
                     window_ff <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
                  end
               end
            end
            ST_KEXP: begin
               // First eight words come straight from the key; the window shifts.
               if (kidx_ff < 6'd8)
                  window_ff <= {window_ff[223:0], window_ff[255:224]};
               else begin
                  window_ff <= {window_ff[223:0], kexp_word};
                  if (kidx_ff[2:0] == 3'd0) rcon_ff <= xtime(rcon_ff);
               end
               if (kidx_ff == 6'd59) begin
                  state_ff <= ST_ENC_LOAD;
                  blk_ff <= '0;
                  setup_pass_ff <= 1'b0;
                  round_ff <= 4'd0;
                  word_ff <= 2'd0;
               end
               kidx_ff <= kidx_ff + 6'd1;
            end
            ST_ENC_LOAD: begin
               // Fetch four round-key words, one per cycle.
               word_ff <= word_ff + 2'd1;
               state_ff <= ST_KRD;
            end
            ST_KRD: begin
               rk_acc_ff <= {rk_acc_ff[95:0], rk_rdata_ff};
               if (word_ff == 2'd0) state_ff <= ST_ENC;
               else word_ff <= word_ff + 2'd1;
            end
            ST_ENC: begin
               if (round_ff == 4'd0) blk_ff <= blk_ff ^ rk_acc_ff;
               else blk_ff <= round_out ^ rk_acc_ff;
               if (round_ff == 4'd14) state_ff <= ST_SETUP_DONE;
               else begin
                  round_ff <= round_ff + 4'd1;
                  state_ff <= ST_ENC_LOAD;
               end
            end
            ST_SETUP_DONE: begin
               if (!keys_ready_ff) begin
                  if (!setup_pass_ff) begin
                     hkey_ff <= blk_ff;
                     setup_pass_ff <= 1'b1;
                     blk_ff <= {nonce_high_ff, nonce_low_ff, 32'd1};
                     round_ff <= 4'd0;
                     state_ff <= ST_ENC_LOAD;
                  end else begin
                     tmask_ff <= blk_ff;
                     keys_ready_ff <= 1'b1;
                     state_ff <= ST_DISPATCH;
                  end
               end else begin
                  ks_ff <= blk_ff;
                  state_ff <= ST_HASH;
                  gz_ff <= '0;
                  gv_ff <= hkey_ff;
                  gcnt_ff <= 4'd0;
                  gy_ff <= acc_ff ^ (direction_ff ?
                           ({req_ff.data_high, req_ff.data_low} & mask)
                           : ((({req_ff.data_high, req_ff.data_low}) ^ blk_ff) & mask));
               end
            end
            ST_DISPATCH: begin
               rsp_ff <= '{result_kind: (req_ff.op == OP_UNUSED) ? 2'd0 : req_ff.op,
                           out_high: 64'd0, out_low: 64'd0, out_bytes: 5'd0,
                           status: STATUS_ERROR};
               gz_ff <= '0;
               gv_ff <= hkey_ff;
               gcnt_ff <= 4'd0;
               case (req_ff.op)
                  OP_AAD: begin
                     if (phase_ff != PHASE_AAD_OPEN || bad_n ||
                         61'(req_ff.byte_count) > AAD_MAX_BYTES - aad_total_ff)
                        state_ff <= ST_RESP;
                     else begin
                        gy_ff <= acc_ff ^ ({req_ff.data_high, req_ff.data_low} & mask);
                        state_ff <= ST_HASH;
                     end
                  end
                  OP_TEXT: begin
                     if (phase_ff == PHASE_TEXT_CLOSED || bad_n ||
                         36'(req_ff.byte_count) > TEXT_MAX_BYTES - text_total_ff)
                        state_ff <= ST_RESP;
                     else begin
                        blk_ff <= {nonce_high_ff, nonce_low_ff, ctr_ff};
                        round_ff <= 4'd0;
                        word_ff <= 2'd0;
                        state_ff <= ST_ENC_LOAD;
                     end
                  end
                  OP_FINISH: begin
                     gy_ff <= acc_ff ^ {aad_total_ff, 3'b0, 25'd0, text_total_ff, 3'b0};
                     state_ff <= ST_HASH;
                  end
                  default: state_ff <= ST_RESP;
               endcase
            end
            ST_HASH: begin
               gz_ff <= gstep[255:128];
               gv_ff <= gstep[127:0];
               gy_ff <= {gy_ff[119:0], 8'd0};
               gcnt_ff <= gcnt_ff + 4'd1;
               if (gcnt_ff == 4'd15) begin
                  state_ff <= ST_RESP;
                  case (req_ff.op)
                     OP_AAD: begin
                        acc_ff <= gstep[255:128];
                        aad_total_ff <= aad_total_ff + 61'(req_ff.byte_count);
                        if (req_ff.byte_count < 5'd16) phase_ff <= PHASE_AAD_CLOSED;
                        rsp_ff.status <= STATUS_OK;
                     end
                     OP_TEXT: begin
                        acc_ff <= gstep[255:128];
                        ctr_ff <= ctr_ff + 32'd1;
                        text_total_ff <= text_total_ff + 36'(req_ff.byte_count);
                        phase_ff <= (req_ff.byte_count < 5'd16) ? PHASE_TEXT_CLOSED
                                                                : PHASE_TEXT_OPEN;
                        rsp_ff <= '{result_kind: OP_TEXT, out_high: text_out[127:64],
                                    out_low: text_out[63:0], out_bytes: req_ff.byte_count,
                                    status: STATUS_OK};
                     end
                     default: begin
                        acc_ff <= '0;
                        ctr_ff <= 32'd2;
                        aad_total_ff <= '0;
                        text_total_ff <= '0;
                        phase_ff <= PHASE_AAD_OPEN;
                        rsp_ff <= '{result_kind: OP_FINISH, out_high: tag[127:64],
                                    out_low: tag[63:0], out_bytes: 5'd16,
                                    status: (direction_ff && (tag != {req_ff.data_high,
                                            req_ff.data_low})) ? STATUS_MISMATCH
                                                               : STATUS_OK};
                     end
                  endcase
               end
            end
            ST_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept_in |-> state_ff == ST_IDLE && !rsp_valid_ff)
      else $error("item accepted while busy");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");
   a_dispatch_keys: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DISPATCH |-> keys_ready_ff)
      else $error("dispatch without expanded keys");

endmodule

/* tb/aes256_gcm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-256-GCM checker
// Watches the register port and both channels, predicts every result of
// the engine in its own AES and GHASH model, and compares them in order.
// ----------------------------------------------------------------------------
module aes256_gcm_checker
   import aes256_gcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output int          fail_count,
   output int          pending
);

   logic [7:0]   sub_table [256];
   logic [255:0] key_value;
   logic [95:0]  iv_value;
   logic         decrypt;
   logic [31:0]  round_words [60];
   logic         schedule_valid;
   logic [127:0] hash_key, tag_pad, hash_state;
   logic [31:0]  block_counter;
   logic [63:0]  aad_total, text_total;
   logic [1:0]   phase;
   rsp_type      expected_results [$];

   function automatic logic [7:0] gf8_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return gf8_mul(x, 8'h02);
   endfunction

   // The substitution table is built from the field inverse and the affine map.
   initial begin
      logic [7:0] inv, r;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h00;
         for (int b = 1; b < 256; b++)
            if (gf8_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
         r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sub_table[a] = r;
      end
   end

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]],
              sub_table[w[7:0]]};
   endfunction

   task automatic build_schedule();
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) round_words[i] = key_value[255-32*i -: 32];
      for (int i = 8; i < 60; i++) begin
         t = round_words[i-1];
         if (i % 8 == 0) begin
            t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = dbl(rcon);
         end else if (i % 8 == 4) begin
            t = subst_word(t);
         end
         round_words[i] = round_words[i-8] ^ t;
      end
   endtask

   function automatic logic [127:0] aes_encrypt(input logic [127:0] din);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) s[i] = din[127-8*i -: 8];
      for (int rnd = 0; rnd <= 14; rnd++) begin
         if (rnd > 0) begin
            for (int i = 0; i < 16; i++) s[i] = sub_table[s[i]];
            for (int row = 0; row < 4; row++)
               for (int c = 0; c < 4; c++)
                  t[4*c+row] = s[4*((c+row)%4)+row];
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               if (rnd < 14) begin
                  s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                  s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                  s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                  s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
               end else begin
                  s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
               s[4*c+k] = s[4*c+k] ^ round_words[4*rnd+c][31-8*k -: 8];
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
      return r;
   endfunction

   task automatic absorb(input logic [127:0] x);
      logic [127:0] y, v, z;
      logic lsb;
      y = hash_state ^ x;
      v = hash_key;
      z = '0;
      for (int i = 127; i >= 0; i--) begin
         if (y[i]) z = z ^ v;
         lsb = v[0];
         v = v >> 1;
         if (lsb) v[127:120] = v[127:120] ^ 8'hE1;
      end
      hash_state = z;
   endtask

   task automatic new_message();
      hash_state = '0;
      block_counter = 32'd2;
      aad_total = '0;
      text_total = '0;
      phase = PHASE_AAD_OPEN;
   endtask

   task automatic predict_result(input req_type req);
      rsp_type      r;
      logic [4:0]   n;
      logic         bad_count;
      logic [127:0] mask, din, dout;
      n = req.byte_count;
      bad_count = (n == 0) || (n > 16);
      mask = (n >= 16) ? {128{1'b1}} : ({128{1'b1}} << (128 - 8 * n));
      din = {req.data_high, req.data_low};
      if (!schedule_valid) begin
         build_schedule();
         hash_key = aes_encrypt('0);
         tag_pad = aes_encrypt({iv_value, 32'd1});
         schedule_valid = 1'b1;
      end
      r = '0;
      r.result_kind = (req.op == OP_UNUSED) ? OP_AAD : req.op;
      r.status = STATUS_ERROR;
      case (req.op)
         OP_AAD: begin
            if (phase == PHASE_AAD_OPEN && !bad_count &&
                64'(n) <= 64'(AAD_MAX_BYTES) - aad_total) begin
               absorb(din & mask);
               aad_total = aad_total + n;
               if (n < 16) phase = PHASE_AAD_CLOSED;
               r.status = STATUS_OK;
            end
         end
         OP_TEXT: begin
            if (phase != PHASE_TEXT_CLOSED && !bad_count &&
                64'(n) <= 64'(TEXT_MAX_BYTES) - text_total) begin
               dout = (din ^ aes_encrypt({iv_value, block_counter})) & mask;
               absorb(decrypt ? (din & mask) : dout);
               block_counter = block_counter + 1;
               text_total = text_total + n;
               phase = (n < 16) ? PHASE_TEXT_CLOSED : PHASE_TEXT_OPEN;
               {r.out_high, r.out_low} = dout;
               r.out_bytes = n;
               r.status = STATUS_OK;
            end
         end
         OP_FINISH: begin
            absorb({aad_total << 3, text_total << 3});
            dout = hash_state ^ tag_pad;
            {r.out_high, r.out_low} = dout;
            r.out_bytes = 5'd16;
            r.status = (decrypt && dout != din) ? STATUS_MISMATCH : STATUS_OK;
            new_message();
         end
         default: ;
      endcase
      expected_results.push_back(r);
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         fail_count++;
         return;
      end
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
         $display("%0t: result_kind expected %0d actual %0d", $time,
                  want.result_kind, got.result_kind);
         fail_count++;
      end
      if (got.out_high !== want.out_high) begin
         $display("%0t: out_high expected %h actual %h", $time, want.out_high, got.out_high);
         fail_count++;
      end
      if (got.out_low !== want.out_low) begin
         $display("%0t: out_low expected %h actual %h", $time, want.out_low, got.out_low);
         fail_count++;
      end
      if (got.out_bytes !== want.out_bytes) begin
         $display("%0t: out_bytes expected %0d actual %0d", $time,
                  want.out_bytes, got.out_bytes);
         fail_count++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         key_value = '0;
         iv_value = '0;
         decrypt = 1'b0;
         schedule_valid = 1'b0;
         new_message();
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_KEY0:      key_value[255:192] = pwdata;
               REG_KEY1:      key_value[191:128] = pwdata;
               REG_KEY2:      key_value[127:64] = pwdata;
               REG_KEY3:      key_value[63:0] = pwdata;
               REG_NONCE_HI:  iv_value[95:32] = pwdata;
               REG_NONCE_LO:  iv_value[31:0] = pwdata[31:0];
               REG_DIRECTION: decrypt = pwdata[0];
               default: ;
            endcase
            if (paddr[5:3] != REG_DIRECTION && paddr[5:3] <= REG_NONCE_LO) begin
               schedule_valid = 1'b0;
               new_message();
            end
         end
         // The result of an item never leaves in the cycle it is accepted.
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (req_valid && req_ready) predict_result(req_data);
      end
      pending = expected_results.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-256-GCM engine testbench
// Drives directed and random messages under several key, IV and direction
// settings with varying back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import aes256_gcm_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   req_type     req_data;
   logic        rsp_valid, rsp_ready;
   rsp_type     rsp_data;
   logic        psel, penable, pwrite, pready;
   logic [5:0]  paddr;
   logic [63:0] pwdata, prdata;
   int          fail_count, pending;
   int          send_idle_pct, stall_pct;
   logic        hold_request;
   rsp_type     seen_results [$];

   aes256_gcm_authenticated_cipher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   aes256_gcm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("testbench: FAIL");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock)
      if (rsp_valid && rsp_ready) seen_results.push_back(rsp_data);

   task automatic write_csr(input logic [2:0] index, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering items and waits until every expected result has come.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [255:0] key, input logic [95:0] iv,
                                input logic dir);
      drain();
      repeat (40) @(posedge clock);
      write_csr(REG_KEY0, key[255:192]);
      write_csr(REG_KEY1, key[191:128]);
      write_csr(REG_KEY2, key[127:64]);
      write_csr(REG_KEY3, key[63:0]);
      write_csr(REG_NONCE_HI, iv[95:32]);
      write_csr(REG_NONCE_LO, {32'h0, iv[31:0]});
      write_csr(REG_DIRECTION, {63'h0, dir});
      @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] op, input logic [63:0] dh,
                            input logic [63:0] dl, input logic [4:0] n);
      req_valid <= 1'b1;
      req_data <= '{op: op, data_high: dh, data_low: dl, byte_count: n};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_noise(inout int sent);
      send_item(2'($urandom_range(3)), rand64(), rand64(), 5'($urandom_range(31)));
      sent++;
   endtask

   // A well-formed message with random content and an occasional broken item.
   task automatic random_message(inout int sent);
      int n_aad, n_text;
      n_aad = $urandom_range(0, 3);
      n_text = $urandom_range(0, 5);
      for (int i = 0; i < n_aad; i++) begin
         if ($urandom_range(9) == 0) random_noise(sent);
         send_item(OP_AAD, rand64(), rand64(),
                   (i == n_aad - 1 && $urandom_range(1)) ? 5'($urandom_range(1, 15)) : 5'd16);
         sent++;
      end
      for (int i = 0; i < n_text; i++) begin
         if ($urandom_range(9) == 0) random_noise(sent);
         send_item(OP_TEXT, rand64(), rand64(),
                   (i == n_text - 1 && $urandom_range(1)) ? 5'($urandom_range(1, 15)) : 5'd16);
         sent++;
      end
      send_item(OP_FINISH, rand64(), rand64(), 5'($urandom_range(31)));
      sent++;
   endtask

   initial begin
      int sent, phase_target;
      rsp_type c1, c2, c3, tag;
      logic [255:0] key;
      logic [95:0] iv;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b0;
      sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: encrypt a message, then decrypt its ciphertext and tag.
      key = {rand64(), rand64(), rand64(), rand64()};
      iv = {rand64(), $urandom};
      load_settings(key, iv, 1'b0);
      send_item(OP_AAD, '1, '1, 5'd16);
      send_item(OP_AAD, 64'h0123_4567_89AB_CDEF, '1, 5'd5);
      send_item(OP_AAD, '1, '1, 5'd16);        // after a partial AAD block
      send_item(OP_TEXT, '0, '0, 5'd16);
      send_item(OP_TEXT, '1, '1, 5'd16);
      send_item(OP_TEXT, '1, '1, 5'd1);
      send_item(OP_TEXT, '1, '1, 5'd16);       // after a partial text block
      send_item(OP_AAD, '0, '0, 5'd16);        // AAD once text has started
      send_item(OP_FINISH, '1, '1, 5'd0);
      drain();
      tag = seen_results[8];
      c1 = seen_results[3];
      c2 = seen_results[4];
      c3 = seen_results[5];
      load_settings(key, iv, 1'b1);
      send_item(OP_AAD, '1, '1, 5'd16);
      send_item(OP_AAD, 64'h0123_4567_89AB_CDEF, '1, 5'd5);
      send_item(OP_TEXT, c1.out_high, c1.out_low, 5'd16);
      send_item(OP_TEXT, c2.out_high, c2.out_low, 5'd16);
      send_item(OP_TEXT, c3.out_high, c3.out_low, 5'd1);
      send_item(OP_FINISH, tag.out_high, tag.out_low, 5'd16);
      send_item(OP_UNUSED, '1, '1, 5'd16);
      send_item(OP_AAD, '1, '1, 5'd0);
      send_item(OP_AAD, '1, '1, 5'd17);
      send_item(OP_TEXT, '1, '1, 5'd31);
      send_item(OP_FINISH, tag.out_high, ~tag.out_low, 5'd31);
      sent = 20;

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: load_settings('0, '0, 1'b0);
            1: load_settings('1, '1, 1'b1);
            2: load_settings({rand64(), rand64(), rand64(), rand64()},
                             {rand64(), $urandom}, 1'b0);
            default: load_settings({rand64(), rand64(), rand64(), rand64()},
                                   {rand64(), 32'hFFFF_FFFF}, 1'b1);
         endcase
         case (p)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 52; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 52; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         phase_target = sent + 333;
         while (sent < phase_target) begin
            if (p == 1 && sent > phase_target - 170 && sent < phase_target - 160) begin
               drain();
            end
            if (p == 2 && sent > phase_target - 200 && !hold_request) begin
               hold_request = 1'b1;
            end
            random_message(sent);
         end
         hold_request = 1'b0;
      end
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/aes256_gcm_pkg.sv
rtl/aes256_gcm_authenticated_cipher.sv
tb/aes256_gcm_checker.sv
tb/testbench.sv
